>>> design/motsa_pkg.sv
// Package: shared constants for the two-list median block.
`timescale 1ns / 1ps

package motsa_pkg;

  // Default capacity of each list
  localparam int LIST_DEPTH_DEF = 1024;

  // Element and result widths
  localparam int ELEM_W = 32;
  localparam int MED_W  = 33;
  localparam int ERR_W  = 2;

  // Result error codes
  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  // What the current selection step reads from the two lists
  typedef enum logic [1:0] {
    MODE_TAKE_A = 2'd0,  // answer sits in the first list
    MODE_TAKE_B = 2'd1,  // answer sits in the second list
    MODE_MIN    = 2'd2,  // answer is the smaller of the two heads
    MODE_CUT    = 2'd3   // compare probes and drop a prefix
  } sel_mode_t;

endpackage

>>> design/median_of_two_sorted_arrays.sv
// Top level: two-list loader and k-th smallest selector reporting twice the median.
//
// Input channel (in_valid / in_stall): one beat per element. in_list_select names
// the list, in_has_value marks a beat that carries an element, in_last ends the
// load. Elements are appended in arrival order and must already be ascending.
// Each list holds LIST_DEPTH elements; further elements are dropped and the
// result reports an overflow error.
// Loading runs at one beat per cycle. After the beat with in_last, in_stall stays
// high while the selector runs: each halving step issues addresses, then evaluates
// the registered RAM read of both lists; an even total needs two selections.
// Setup comes first, and the result is valid from the cycle after the last step.
// Result channel (out_valid / out_stall): one beat per load, carrying the median
// times two and an error code (ok, empty union, overflow). The result holds in its
// register while out_stall is high; loading of the next lists goes on meanwhile,
// and setup for the next closing beat waits until the held result leaves.
// Reset (rst_n low, synchronous) empties both lists and drops any pending result;
// list memory contents are not cleared and are never read past the counts.
`timescale 1ns / 1ps

module median_of_two_sorted_arrays
  import motsa_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input beats
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_list_select,
  input  logic                    in_has_value,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                    in_last,
  // result beats
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [MED_W-1:0] out_median_doubled,
  output logic [ERR_W-1:0]        out_error_code
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);   // count / position
  localparam int KW = CW + 1;                   // rank k and total
  localparam int SW = CW + 2;                   // position plus rank

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CW-1:0]           pos_a_r, pos_a_nxt, pos_b_r, pos_b_nxt;
  logic [CW-1:0]           na_r, na_nxt, nb_r, nb_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  sel_mode_t               mode_r, mode_nxt;
  logic                    pass_r, pass_nxt;
  logic                    odd_r, odd_nxt;
  logic signed [ELEM_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [MED_W-1:0] med_r, med_nxt;
  logic [ERR_W-1:0]        err_r, err_nxt;

  logic                    in_acc;
  logic                    wr_a, wr_b;
  logic [AW-1:0]           rd_addr_a, rd_addr_b;
  logic signed [ELEM_W-1:0] rd_a, rd_b;

  logic [KW-1:0]           total;
  logic [KW-1:0]           half;
  logic [SW-1:0]           idx_a, idx_b, cut_a, cut_b, lim_a, lim_b, na_w, nb_w;
  logic                    found;
  logic signed [ELEM_W-1:0] found_val;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Append accepted elements while the list has room
  assign wr_a = in_acc && in_has_value && !in_list_select && (cnt_a_r < CW'(LIST_DEPTH));
  assign wr_b = in_acc && in_has_value &&  in_list_select && (cnt_b_r < CW'(LIST_DEPTH));

  motsa_ram #(.WIDTH(ELEM_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  motsa_ram #(.WIDTH(ELEM_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  // Probe arithmetic for the current halving step
  assign total = KW'(cnt_a_r) + KW'(cnt_b_r);
  assign half  = k_r >> 1;
  assign idx_a = SW'(pos_a_r) + SW'(k_r) - SW'(1);
  assign idx_b = SW'(pos_b_r) + SW'(k_r) - SW'(1);
  assign cut_a = SW'(pos_a_r) + SW'(half) - SW'(1);
  assign cut_b = SW'(pos_b_r) + SW'(half) - SW'(1);
  assign lim_a = SW'(cnt_a_r) - SW'(1);
  assign lim_b = SW'(cnt_b_r) - SW'(1);
  assign na_w  = (cut_a > lim_a) ? lim_a : cut_a;
  assign nb_w  = (cut_b > lim_b) ? lim_b : cut_b;

  // Sequencer: load, then iterate the shared probe/compare step
  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ovf_nxt       = ovf_r;
    pos_a_nxt     = pos_a_r;
    pos_b_nxt     = pos_b_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    k_nxt         = k_r;
    mode_nxt      = mode_r;
    pass_nxt      = pass_r;
    odd_nxt       = odd_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    med_nxt       = med_r;
    err_nxt       = err_r;
    rd_addr_a     = pos_a_r[AW-1:0];
    rd_addr_b     = pos_b_r[AW-1:0];
    found         = 1'b0;
    found_val     = '0;

    // Retire the held result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (wr_a) cnt_a_nxt = cnt_a_r + CW'(1);
          if (wr_b) cnt_b_nxt = cnt_b_r + CW'(1);
          if (in_has_value && !wr_a && !wr_b) ovf_nxt = 1'b1;
          if (in_last) state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        // Hold until the previous result has left
        if (!out_valid_r) begin
          pos_a_nxt = '0;
          pos_b_nxt = '0;
          pass_nxt  = 1'b0;
          odd_nxt   = total[0];
          k_nxt     = (total + KW'(1)) >> 1;
          if (total == '0) begin
            med_nxt       = '0;
            err_nxt       = ERR_EMPTY;
            out_valid_nxt = 1'b1;
            cnt_a_nxt     = '0;
            cnt_b_nxt     = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end

      S_ISSUE: begin
        state_nxt = S_EVAL;
        if (pos_a_r >= cnt_a_r) begin
          rd_addr_b = idx_b[AW-1:0];
          mode_nxt  = MODE_TAKE_B;
          if (idx_b >= SW'(cnt_b_r)) begin
            found = 1'b1;
          end
        end else if (pos_b_r >= cnt_b_r) begin
          rd_addr_a = idx_a[AW-1:0];
          mode_nxt  = MODE_TAKE_A;
          if (idx_a >= SW'(cnt_a_r)) begin
            found = 1'b1;
          end
        end else if (k_r <= KW'(1)) begin
          mode_nxt = MODE_MIN;
        end else begin
          rd_addr_a = na_w[AW-1:0];
          rd_addr_b = nb_w[AW-1:0];
          na_nxt    = na_w[CW-1:0];
          nb_nxt    = nb_w[CW-1:0];
          mode_nxt  = MODE_CUT;
        end
      end

      S_EVAL: begin
        case (mode_r)
          MODE_TAKE_A: begin
            found     = 1'b1;
            found_val = rd_a;
          end
          MODE_TAKE_B: begin
            found     = 1'b1;
            found_val = rd_b;
          end
          MODE_MIN: begin
            found     = 1'b1;
            found_val = (rd_a < rd_b) ? rd_a : rd_b;
          end
          default: begin
            // Drop the prefix that ends at the smaller probe
            state_nxt = S_ISSUE;
            if (rd_a <= rd_b) begin
              k_nxt     = k_r - (KW'(na_r) - KW'(pos_a_r) + KW'(1));
              pos_a_nxt = na_r + CW'(1);
            end else begin
              k_nxt     = k_r - (KW'(nb_r) - KW'(pos_b_r) + KW'(1));
              pos_b_nxt = nb_r + CW'(1);
            end
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Fold a selected value into the result
    if (found) begin
      if (!pass_r && !odd_r) begin
        acc_nxt   = found_val;
        pass_nxt  = 1'b1;
        k_nxt     = (total >> 1) + KW'(1);
        pos_a_nxt = '0;
        pos_b_nxt = '0;
        state_nxt = S_ISSUE;
      end else begin
        if (!pass_r) begin
          med_nxt = {found_val, 1'b0};
        end else begin
          med_nxt = {acc_r[ELEM_W-1], acc_r} + {found_val[ELEM_W-1], found_val};
        end
        err_nxt       = ovf_r ? ERR_OVERFLOW : ERR_OK;
        out_valid_nxt = 1'b1;
        cnt_a_nxt     = '0;
        cnt_b_nxt     = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    pos_a_r <= pos_a_nxt;
    pos_b_r <= pos_b_nxt;
    na_r    <= na_nxt;
    nb_r    <= nb_nxt;
    k_r     <= k_nxt;
    mode_r  <= mode_nxt;
    pass_r  <= pass_nxt;
    odd_r   <= odd_nxt;
    acc_r   <= acc_nxt;
    med_r   <= med_nxt;
    err_r   <= err_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = med_r;
  assign out_error_code     = err_r;

  // A closing beat always starts the selector
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> state_r == S_SETUP)
    else $error("closing beat did not start selection");

  // Counts never pass the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(LIST_DEPTH) && cnt_b_r <= CW'(LIST_DEPTH))
    else $error("list count above capacity");

  // Positions stay within the loaded lists while selecting
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE |-> pos_a_r <= cnt_a_r && pos_b_r <= cnt_b_r)
    else $error("selection position out of range");

  // The rank being searched is never zero
  a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE |-> k_r != '0)
    else $error("rank reached zero");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(med_r) && $stable(err_r))
    else $error("stalled result changed");

endmodule

>>> design/motsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module motsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/tb_median_of_two_sorted_arrays.sv
// Testbench for the two-list median block: random sorted loads checked against a k-th selector.
`timescale 1ns / 1ps

module tb_median_of_two_sorted_arrays;
  import motsa_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int INT_MAX        = int'(32'h7fff_ffff);
  localparam int INT_MIN        = int'(32'h8000_0000);

  typedef struct {
    logic signed [MED_W-1:0] median;
    logic [ERR_W-1:0]        err;
  } median_beat_t;

  // Track both lists as the block sees them and queue the median each load should give
  class median_scoreboard;
    logic signed [ELEM_W-1:0] list_a [LIST_DEPTH_DEF];
    logic signed [ELEM_W-1:0] list_b [LIST_DEPTH_DEF];
    int unsigned  count_a;
    int unsigned  count_b;
    bit           overflow;
    median_beat_t median_q[$];
    int           errors;

    function new();
      count_a  = 0;
      count_b  = 0;
      overflow = 0;
      errors   = 0;
    endfunction

    function int pending();
      return median_q.size();
    endfunction

    // k-th smallest (k from 1) of the union, by halving k and dropping a prefix
    function logic signed [ELEM_W-1:0] kth_smallest(int unsigned k);
      int unsigned pa, pb, ia, ib, half;
      logic signed [ELEM_W-1:0] pick;
      bit done;
      pa   = 0;
      pb   = 0;
      pick = '0;
      done = 0;
      while (!done) begin
        if (pa >= count_a) begin
          ib = pb + k - 1;
          if (ib < count_b) pick = list_b[ib];
          done = 1;
        end else if (pb >= count_b) begin
          ia = pa + k - 1;
          if (ia < count_a) pick = list_a[ia];
          done = 1;
        end else if (k <= 1) begin
          pick = (list_a[pa] < list_b[pb]) ? list_a[pa] : list_b[pb];
          done = 1;
        end else begin
          half = k / 2;
          ia   = pa + half - 1;
          ib   = pb + half - 1;
          if (ia > count_a - 1) ia = count_a - 1;
          if (ib > count_b - 1) ib = count_b - 1;
          if (list_a[ia] <= list_b[ib]) begin
            k  -= ia - pa + 1;
            pa  = ia + 1;
          end else begin
            k  -= ib - pb + 1;
            pb  = ib + 1;
          end
        end
      end
      return pick;
    endfunction

    // Append an accepted element; on the closing beat queue the expected result
    function void note_beat(logic sel, logic has, logic signed [ELEM_W-1:0] value, logic lst);
      int unsigned  total;
      longint       twice;
      median_beat_t want;
      if (has) begin
        if (!sel) begin
          if (count_a < LIST_DEPTH_DEF) begin
            list_a[count_a] = value;
            count_a++;
          end else begin
            overflow = 1;
          end
        end else begin
          if (count_b < LIST_DEPTH_DEF) begin
            list_b[count_b] = value;
            count_b++;
          end else begin
            overflow = 1;
          end
        end
      end
      if (lst) begin
        total = count_a + count_b;
        twice = 0;
        if (total == 0) begin
          want.err = ERR_EMPTY;
        end else begin
          if (total % 2 != 0)
            twice = 2 * longint'(kth_smallest((total + 1) / 2));
          else
            twice = longint'(kth_smallest(total / 2)) + longint'(kth_smallest(total / 2 + 1));
          want.err = overflow ? ERR_OVERFLOW : ERR_OK;
        end
        want.median = twice[MED_W-1:0];
        median_q.push_back(want);
        count_a  = 0;
        count_b  = 0;
        overflow = 0;
      end
    endfunction

    // Compare a result beat with the oldest pending load
    function void check_median(logic signed [MED_W-1:0] med, logic [ERR_W-1:0] err);
      median_beat_t want;
      if (median_q.size() == 0) begin
        $error("unexpected result beat: median_doubled %0d, error_code %0d", med, err);
        errors++;
        return;
      end
      want = median_q.pop_front();
      if (med !== want.median) begin
        $error("median_doubled: expected %0d, actual %0d", want.median, med);
        errors++;
      end
      if (err !== want.err) begin
        $error("error_code: expected %0d, actual %0d", want.err, err);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_list_select;
  logic                     in_has_value;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [MED_W-1:0]  out_median_doubled;
  logic [ERR_W-1:0]         out_error_code;

  median_scoreboard sb = new();
  bit tx_idle       = 1'b1;
  bit rx_idle       = 1'b1;
  bit hold_results  = 1'b0;
  int item_count    = 0;
  int quiet_cycles  = 0;

  median_of_two_sorted_arrays i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_list_select    (in_list_select),
    .in_has_value      (in_has_value),
    .in_element_value  (in_element_value),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_median_doubled(out_median_doubled),
    .out_error_code    (out_error_code)
  );

  always #5 clk = ~clk;

  // Feed accepted beats to the scoreboard on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_beat(in_list_select, in_has_value, in_element_value, in_last);
    if (rst_n && out_valid && !out_stall)
      sb.check_median(out_median_doubled, out_error_code);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("median_of_two_sorted_arrays: mismatch");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_stall
    int n;
    out_stall = 1'b0;
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_results = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (rx_idle ? $urandom_range(1, 6) : 1) @(posedge clk);
      end
    end
  end

  // Offer one beat, maybe after an idle burst, and hold it until accepted
  task automatic send_beat(input logic sel, input logic has,
                           input logic signed [ELEM_W-1:0] value, input logic lst);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_list_select   <= sel;
    in_has_value     <= has;
    in_element_value <= value;
    in_last          <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Interleave two lists in order, sprinkle empty beats, close on an element or a bare marker
  task automatic play_load(input int qa[$], input int qb[$], input bit bare_end);
    int  ia, ib;
    bit  take_b, closing;
    ia = 0;
    ib = 0;
    while (ia < qa.size() || ib < qb.size()) begin
      if ($urandom_range(0, 7) == 0) begin
        send_beat($urandom_range(0, 1), 1'b0, $urandom, 1'b0);
        item_count++;
      end
      take_b  = (ia == qa.size()) || (ib < qb.size() && $urandom_range(0, 1) == 1);
      closing = !bare_end && (ia + ib + 1 == qa.size() + qb.size());
      if (take_b) begin
        send_beat(1'b1, 1'b1, qb[ib], closing);
        ib++;
      end else begin
        send_beat(1'b0, 1'b1, qa[ia], closing);
        ia++;
      end
      item_count++;
    end
    if (bare_end || qa.size() + qb.size() == 0) begin
      send_beat($urandom_range(0, 1), 1'b0, $urandom, 1'b1);
      item_count++;
    end
  endtask

  function automatic int pick_value(int mode);
    case (mode)
      0: return $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 4))
          0: return INT_MIN;
          1: return INT_MAX;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly short lists, now and then a long one
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 97) return $urandom_range(0, 24);
    return $urandom_range(60, 200);
  endfunction

  task automatic random_load(input int na, input int nb, input bit sorted, input bit bare_end);
    int qa[$], qb[$];
    int mode;
    mode = $urandom_range(0, 3);
    repeat (na) qa.push_back(pick_value(mode));
    repeat (nb) qb.push_back(pick_value(mode));
    if (sorted) begin
      qa.sort();
      qb.sort();
    end
    play_load(qa, qb, bare_end);
  endtask

  // Drop valid so the last beat is not offered again, then drain
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int qa[$], qb[$];
    int loads;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_list_select   = 1'b0;
    in_has_value     = 1'b0;
    in_element_value = '0;
    in_last          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty union: a bare closing beat
    play_load(qa, qb, 1'b1);
    // Single extremes, element on the closing beat
    qa = '{INT_MAX};
    play_load(qa, qb, 1'b0);
    qa.delete();
    qb = '{INT_MIN};
    play_load(qa, qb, 1'b0);
    // Even totals at both extremes, one closed by a bare marker
    qa = '{INT_MAX};
    qb = '{INT_MAX};
    play_load(qa, qb, 1'b1);
    qa = '{INT_MIN};
    qb = '{INT_MIN};
    play_load(qa, qb, 1'b0);
    // Ordinary odd total, even total within one list, repeated values
    qa = '{-5, 3, 7};
    qb = '{1, 2};
    play_load(qa, qb, 1'b0);
    qa = '{0, 0, 0, 0};
    qb.delete();
    play_load(qa, qb, 1'b1);
    qa = '{-1};
    qb = '{-1, 100};
    play_load(qa, qb, 1'b0);
    // Unsorted input still selects something
    qa = '{9, 1, 5};
    qb = '{4};
    play_load(qa, qb, 1'b0);

    // Random loads: long result hold early, a full drain midway, a tail without idle gaps or stall bursts
    loads = 0;
    while (item_count < 450 || loads < 16) begin
      if (loads == 3) hold_results = 1'b1;
      if (loads == 8) wait_for_results();
      if (loads == 15) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      random_load(pick_size(), pick_size(), $urandom_range(0, 9) != 0,
                  $urandom_range(0, 3) == 0);
      loads++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("median_of_two_sorted_arrays: match");
    else
      $display("median_of_two_sorted_arrays: mismatch");
    $finish;
  end

endmodule
